// ===== sv/dmv_pkg.sv =====
// ----------------------------------------------------------------------------
// dmv_pkg
// Shared types and constants for the dense matrix-vector multiplier: request
// and response beats, the beat that travels down the cell chain, opcodes and
// register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package dmv_pkg;

   // Default matrix order supported by the storage and the cell chain.
   localparam int DMV_MAX_DIM = 16;

   // Field widths fixed by the interface.
   localparam int OpW       = 2;
   localparam int FlatIdxW  = 8;
   localparam int ElemW     = 16;
   localparam int ProdW     = 2 * ElemW;
   localparam int SumW      = 40;
   localparam int RowFieldW = 4;
   localparam int DimW      = 5;
   localparam int CsrIdxW   = 1;

   // Reset value of the dimension register.
   localparam logic [DimW-1:0] DIM_RESET = 5'd16;

   // Request opcodes.
   localparam logic [OpW-1:0] OP_WRITE_MATRIX = 2'd0;
   localparam logic [OpW-1:0] OP_WRITE_VECTOR = 2'd1;
   localparam logic [OpW-1:0] OP_START        = 2'd2;

   // Configuration register indexes.
   localparam logic [CsrIdxW-1:0] CSR_DIMENSION    = 1'b0;
   localparam logic [CsrIdxW-1:0] CSR_COLUMN_MAJOR = 1'b1;

   // One request beat.
   typedef struct packed {
      logic [OpW-1:0]             opcode;
      logic [FlatIdxW-1:0]        flat_index;
      logic signed [ElemW-1:0]    element_value;
   } dmv_req_type;

   // One response beat.
   typedef struct packed {
      logic [RowFieldW-1:0]       row_index;
      logic signed [SumW-1:0]     row_sum;
      logic                       last_row;
   } dmv_rsp_type;

   // A product travelling down the cell chain.
   typedef struct packed {
      logic                       valid;
      logic                       first;   // first column of its row
      logic                       tail;    // final product of the whole start
      logic signed [ProdW-1:0]    prod;
   } dmv_beat_type;

endpackage

`default_nettype wire

// ===== sv/dmv_cell.sv =====
// ----------------------------------------------------------------------------
// dmv_cell
// One cell of the accumulation chain. The cell owns the row sum of one matrix
// row. Every cycle it passes the incoming product on to its neighbor; a
// product of its own row restarts its sum on the first column, else adds to
// it. During unload the sums shift one cell toward the head of the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module dmv_cell import dmv_pkg::*; #(
   parameter int MAX_DIM = DMV_MAX_DIM,
   parameter int CELL_ID = 0
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire dmv_beat_type                      beat_in,
   input  wire logic [$clog2(MAX_DIM)-1:0]        row_in,
   output      dmv_beat_type                      beat_out,
   output      logic [$clog2(MAX_DIM)-1:0]        row_out,
   input  wire logic                              shift,
   input  wire logic signed [SumW-1:0]            acc_in,
   output      logic signed [SumW-1:0]            acc_out
);

   localparam int IdxW = $clog2(MAX_DIM);
   localparam logic [IdxW-1:0] MyRow = IdxW'(CELL_ID);

   dmv_beat_type            beat_ff;
   logic [IdxW-1:0]         row_ff;
   logic signed [SumW-1:0]  acc_ff;
   logic signed [SumW-1:0]  acc_in_next;
   logic signed [SumW-1:0]  prod_ext;
   logic                    hit;

   // Sign-extend the product to the width of the sum.
   assign prod_ext = {{(SumW - ProdW){beat_in.prod[ProdW-1]}}, beat_in.prod};
   assign hit      = beat_in.valid && (row_in == MyRow);

   // Next value of the row sum: unload shift, restart on the first column,
   // or accumulate.
   always_comb begin
      acc_in_next = acc_ff;
      if (shift) begin
         acc_in_next = acc_in;
      end else if (hit) begin
         if (beat_in.first) begin
            acc_in_next = prod_ext;
         end else begin
            acc_in_next = acc_ff + prod_ext;
         end
      end
   end

   // Pass the beat on to the neighbor.
   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else begin
         beat_ff.valid <= beat_in.valid;
      end
      beat_ff.first <= beat_in.first;
      beat_ff.tail  <= beat_in.tail;
      beat_ff.prod  <= beat_in.prod;
      row_ff        <= row_in;
      acc_ff        <= acc_in_next;
   end

   assign beat_out = beat_ff;
   assign row_out  = row_ff;
   assign acc_out  = acc_ff;

endmodule

`default_nettype wire

// ===== sv/dense_matrix_vector_multiply.sv =====
// ----------------------------------------------------------------------------
// dense_matrix_vector_multiply
// Computes y = A * x for a square matrix of signed Q8.8 elements and returns
// one exact signed Q24.16 sum per row. Products are formed by one multiplier
// and travel down a chain of MAX_DIM cells, each of which accumulates one row.
//
//   channel   ports                        direction  accepted when
//   request   start, busy, req_data        in         start && !busy
//   response  rsp_valid, rsp_data          out        rsp_valid (no stall)
//   config    csr_valid, csr_ready,        in         csr_valid && csr_ready
//             csr_index, csr_wdata
//
// Matrix or vector loads can be issued every cycle while busy is low.
// A start reads the matrix memory once per element, so it runs through the
// feed, chain drain and unload states; busy stays high for that whole time.
// Each response beat is registered and appears in the cycle after its unload
// cycle, so the last one appears in the first cycle in which busy is low.
// Reset is synchronous and clears control state and the registers; the
// memories hold whatever they held until written.
// The response side cannot stall: each beat is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dense_matrix_vector_multiply import dmv_pkg::*; #(
   parameter int MAX_DIM = DMV_MAX_DIM
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output      logic                 busy,
   input  wire dmv_req_type          req_data,
   output      logic                 rsp_valid,
   output      dmv_rsp_type          rsp_data,
   input  wire logic                 csr_valid,
   output      logic                 csr_ready,
   input  wire logic [CsrIdxW-1:0]   csr_index,
   input  wire logic [DimW-1:0]      csr_wdata
);

   localparam int IdxW     = $clog2(MAX_DIM);
   localparam int CntW     = $clog2(MAX_DIM + 1);
   localparam int MatDepth = MAX_DIM * MAX_DIM;
   localparam int MatAw    = $clog2(MatDepth);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_FEED   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_UNLOAD = 4'b1000
   } dmv_state_type;

   dmv_state_type           state_ff, state_in;
   logic [DimW-1:0]         dim_ff;
   logic                    col_major_ff;
   logic [CntW-1:0]         n_ff, n_in;
   logic [IdxW-1:0]         last_ff, last_in;
   logic                    layout_ff;
   logic [IdxW-1:0]         row_ff, row_in;
   logic [IdxW-1:0]         col_ff, col_in;
   logic [MatAw-1:0]        addr_ff, addr_in;
   logic [IdxW-1:0]         out_cnt_ff, out_cnt_in;

   logic [ElemW-1:0]        mat_mem [MatDepth];
   logic [ElemW-1:0]        vec_mem [MAX_DIM];
   logic signed [ElemW-1:0] mat_rd_ff;
   logic signed [ElemW-1:0] vec_rd_ff;

   logic                    s1_valid_ff;
   logic                    s1_first_ff;
   logic                    s1_tail_ff;
   logic [IdxW-1:0]         s1_row_ff;
   dmv_beat_type            head_beat_ff;
   logic [IdxW-1:0]         head_row_ff;

   dmv_beat_type            beat_w [MAX_DIM + 1];
   logic [IdxW-1:0]         row_w  [MAX_DIM + 1];
   logic signed [SumW-1:0]  acc_w  [MAX_DIM + 1];

   logic                    rsp_valid_ff;
   dmv_rsp_type             rsp_data_ff;

   logic                    accept;
   logic                    go;
   logic                    mat_we;
   logic                    vec_we;
   logic                    issue;
   logic                    end_row;
   logic                    end_all;
   logic                    chain_done;
   logic                    shift;

   // Request decode.
   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign go     = accept && (req_data.opcode == OP_START);
   assign mat_we = accept && (req_data.opcode == OP_WRITE_MATRIX)
                   && (int'(req_data.flat_index) < MatDepth);
   assign vec_we = accept && (req_data.opcode == OP_WRITE_VECTOR)
                   && (int'(req_data.flat_index) < MAX_DIM);

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff       <= DIM_RESET;
         col_major_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DIMENSION: begin
               dim_ff <= csr_wdata;
            end
            CSR_COLUMN_MAJOR: begin
               col_major_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Matrix order in use: zero counts as one, larger than MAX_DIM is capped.
   always_comb begin
      if (dim_ff == '0) begin
         n_in = CntW'(1);
      end else if (int'(dim_ff) > MAX_DIM) begin
         n_in = CntW'(MAX_DIM);
      end else begin
         n_in = CntW'(dim_ff);
      end
      last_in = IdxW'(n_in - CntW'(1));
   end

   // Element walk in row order; the address follows the layout.
   assign issue   = (state_ff == ST_FEED);
   assign end_row = (col_ff == last_ff);
   assign end_all = end_row && (row_ff == last_ff);

   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      addr_in = addr_ff;
      if (go) begin
         row_in  = '0;
         col_in  = '0;
         addr_in = '0;
      end else if (issue) begin
         if (end_row) begin
            col_in = '0;
            row_in = row_ff + IdxW'(1);
            if (layout_ff) begin
               addr_in = MatAw'(row_ff) + MatAw'(1);
            end else begin
               addr_in = addr_ff + MatAw'(1);
            end
         end else begin
            col_in = col_ff + IdxW'(1);
            if (layout_ff) begin
               addr_in = addr_ff + MatAw'(n_ff);
            end else begin
               addr_in = addr_ff + MatAw'(1);
            end
         end
      end
   end

   // The tail beat leaving the last cell means every row sum is complete.
   assign chain_done = beat_w[MAX_DIM].valid && beat_w[MAX_DIM].tail
                       && (row_w[MAX_DIM] == last_ff);
   assign shift      = (state_ff == ST_UNLOAD);

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      out_cnt_in = out_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (go) begin
               state_in = ST_FEED;
            end
         end
         ST_FEED: begin
            if (end_all) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            out_cnt_in = '0;
            if (chain_done) begin
               state_in = ST_UNLOAD;
            end
         end
         ST_UNLOAD: begin
            out_cnt_in = out_cnt_ff + IdxW'(1);
            if (out_cnt_ff == last_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (go) begin
         n_ff      <= n_in;
         last_ff   <= last_in;
         layout_ff <= col_major_ff;
      end
      row_ff     <= row_in;
      col_ff     <= col_in;
      addr_ff    <= addr_in;
      out_cnt_ff <= out_cnt_in;
   end

   // Matrix and vector memories: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mat_we) begin
         mat_mem[MatAw'(req_data.flat_index)] <= req_data.element_value;
      end
      mat_rd_ff <= mat_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (vec_we) begin
         vec_mem[IdxW'(req_data.flat_index)] <= req_data.element_value;
      end
      vec_rd_ff <= vec_mem[col_ff];
   end

   // Tags alongside the memory read, then the multiplier stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff        <= 1'b0;
         head_beat_ff.valid <= 1'b0;
      end else begin
         s1_valid_ff        <= issue;
         head_beat_ff.valid <= s1_valid_ff;
      end
      s1_first_ff        <= (col_ff == '0);
      s1_tail_ff         <= end_all;
      s1_row_ff          <= row_ff;
      head_beat_ff.first <= s1_first_ff;
      head_beat_ff.tail  <= s1_tail_ff;
      head_beat_ff.prod  <= mat_rd_ff * vec_rd_ff;
      head_row_ff        <= s1_row_ff;
   end

   // Chain of accumulation cells, one per row.
   assign beat_w[0]      = head_beat_ff;
   assign row_w[0]       = head_row_ff;
   assign acc_w[MAX_DIM] = '0;

   for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
      dmv_cell #(
         .MAX_DIM (MAX_DIM),
         .CELL_ID (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .beat_in  (beat_w[k]),
         .row_in   (row_w[k]),
         .beat_out (beat_w[k + 1]),
         .row_out  (row_w[k + 1]),
         .shift    (shift),
         .acc_in   (acc_w[k + 1]),
         .acc_out  (acc_w[k])
      );
   end

   // Response register: the head cell's sum leaves once per unload cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= shift;
      end
      rsp_data_ff.row_index <= RowFieldW'(out_cnt_ff);
      rsp_data_ff.row_sum   <= acc_w[0];
      rsp_data_ff.last_row  <= (out_cnt_ff == last_ff);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== tb/sv/dmv_row_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmv_row_checker
// Watches the request, response and register channels of the dense
// matrix-vector multiplier. It keeps its own copy of the matrix, the vector
// and both registers, works out every row sum of each accepted start beat,
// and compares each response beat field by field with the oldest one waiting.
// ----------------------------------------------------------------------------

module dmv_row_checker import dmv_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                busy,
   input  wire dmv_req_type         req_data,
   input  wire logic                rsp_valid,
   input  wire dmv_rsp_type         rsp_data,
   input  wire logic                csr_valid,
   input  wire logic                csr_ready,
   input  wire logic [CsrIdxW-1:0]  csr_index,
   input  wire logic [DimW-1:0]     csr_wdata,
   output int                       mismatch_count,
   output int                       rows_pending,
   output int                       rows_checked
);

   localparam int MatDepth = DMV_MAX_DIM * DMV_MAX_DIM;

   // Shadow copies of the stores and the registers.
   logic signed [ElemW-1:0] matrix_copy [MatDepth];
   logic signed [ElemW-1:0] vector_copy [DMV_MAX_DIM];
   logic [DimW-1:0]         dim_reg;
   logic                    col_major;

   // Row sums still owed by the block, oldest first.
   dmv_rsp_type expected_rows [$];

   // A dimension of zero acts as one; anything above the maximum is clamped.
   function automatic int active_order();
      if (dim_reg == 0)
         return 1;
      if (dim_reg > DMV_MAX_DIM)
         return DMV_MAX_DIM;
      return int'(dim_reg);
   endfunction

   // Computes every row of y = A * x with the layout in force right now.
   task automatic predict_rows();
      int          n;
      int          addr;
      longint      acc;
      dmv_rsp_type row_beat;
      n = active_order();
      for (int row = 0; row < n; row++) begin
         acc = 0;
         for (int col = 0; col < n; col++) begin
            addr = col_major ? col * n + row : row * n + col;
            acc += longint'(matrix_copy[addr]) * longint'(vector_copy[col]);
         end
         row_beat.row_index = row[RowFieldW-1:0];
         row_beat.row_sum   = acc[SumW-1:0];
         row_beat.last_row  = (row == n - 1);
         expected_rows.push_back(row_beat);
      end
   endtask

   // Compares one response beat with the oldest predicted row.
   task automatic check_row(input dmv_rsp_type got);
      dmv_rsp_type want;
      if (expected_rows.size() == 0) begin
         $display("%0t: unexpected row beat: expected none, actual row %0d sum %0d last %0b",
                  $time, got.row_index, got.row_sum, got.last_row);
         mismatch_count++;
      end else begin
         want = expected_rows.pop_front();
         rows_checked++;
         if (got.row_index !== want.row_index) begin
            $display("%0t: row_index expected %0d actual %0d",
                     $time, want.row_index, got.row_index);
            mismatch_count++;
         end
         if (got.row_sum !== want.row_sum) begin
            $display("%0t: row_sum of row %0d expected %0d actual %0d",
                     $time, want.row_index, want.row_sum, got.row_sum);
            mismatch_count++;
         end
         if (got.last_row !== want.last_row) begin
            $display("%0t: last_row of row %0d expected %0b actual %0b",
                     $time, want.row_index, want.last_row, got.last_row);
            mismatch_count++;
         end
      end
   endtask

   // Everything is sampled at the rising edge, before the block updates.
   always @(posedge clock) begin
      if (reset) begin
         dim_reg        = DIM_RESET;
         col_major      = 1'b0;
         mismatch_count = 0;
         rows_checked   = 0;
         expected_rows.delete();
      end else begin
         // Register writes.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DIMENSION:    dim_reg = csr_wdata;
               CSR_COLUMN_MAJOR: col_major = csr_wdata[0];
               default: ;
            endcase
         end

         // Response beats.
         if (rsp_valid)
            check_row(rsp_data);

         // Request beats; vector writes past the end and the spare opcode do nothing.
         if (start && !busy) begin
            case (req_data.opcode)
               OP_WRITE_MATRIX: matrix_copy[req_data.flat_index] = req_data.element_value;
               OP_WRITE_VECTOR: begin
                  if (req_data.flat_index < DMV_MAX_DIM)
                     vector_copy[req_data.flat_index] = req_data.element_value;
               end
               OP_START: predict_rows();
               default: ;
            endcase
         end
      end
      rows_pending = expected_rows.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the dense matrix-vector multiplier with a short directed sequence
// (extreme elements, both layouts, ignored beats, clamped dimensions) and then
// with random load bursts followed by multiplies over many register settings.
// The row checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------

module tb_top;
   import dmv_pkg::*;

   localparam logic [OpW-1:0] OP_UNUSED = 2'd3;
   localparam int MatDepth    = DMV_MAX_DIM * DMV_MAX_DIM;
   localparam int BeatBudget  = 330;
   localparam int DrainCycles = DMV_MAX_DIM + 8;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               start     = 1'b0;
   logic               busy;
   dmv_req_type        req_data  = '0;
   logic               rsp_valid;
   dmv_rsp_type        rsp_data;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [DimW-1:0]    csr_wdata = '0;

   int mismatch_count;
   int rows_pending;
   int rows_checked;

   // Which entries have been loaded, so a multiply never reads an unwritten one.
   bit mat_loaded [MatDepth];
   bit vec_loaded [DMV_MAX_DIM];
   int order         = DMV_MAX_DIM;
   int idle_pct      = 0;
   int beats_sent    = 0;
   int starts_sent   = 0;
   int settings_used = 0;

   always #1 clock = ~clock;

   dense_matrix_vector_multiply uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   dmv_row_checker row_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .rows_pending   (rows_pending),
      .rows_checked   (rows_checked)
   );

   function automatic dmv_req_type make_beat(input logic [OpW-1:0] op, input int idx,
                                             input logic [ElemW-1:0] value);
      dmv_req_type beat;
      beat.opcode        = op;
      beat.flat_index    = idx[FlatIdxW-1:0];
      beat.element_value = value;
      return beat;
   endfunction

   // Q8.8 element, weighted toward the extremes.
   function automatic logic [ElemW-1:0] pick_element();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'hFFFF;
         3: return 16'h0000;
         default: return ElemW'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   // Sends one request beat. Called at a falling edge; returns at the falling
   // edge after acceptance with start still high, so the caller acts next.
   task automatic send_beat(input dmv_req_type beat);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      @(negedge clock);
      case (beat.opcode)
         OP_WRITE_MATRIX: mat_loaded[beat.flat_index] = 1'b1;
         OP_WRITE_VECTOR: begin
            if (beat.flat_index < DMV_MAX_DIM)
               vec_loaded[beat.flat_index] = 1'b1;
         end
         default: ;
      endcase
      beats_sent++;
   endtask

   // Loads whatever the coming multiply would read unwritten, then starts it.
   task automatic run_multiply();
      for (int addr = 0; addr < order * order; addr++)
         if (!mat_loaded[addr])
            send_beat(make_beat(OP_WRITE_MATRIX, addr, pick_element()));
      for (int addr = 0; addr < order; addr++)
         if (!vec_loaded[addr])
            send_beat(make_beat(OP_WRITE_VECTOR, addr, pick_element()));
      send_beat(make_beat(OP_START, $urandom_range(0, 255), pick_element()));
      starts_sent++;
   endtask

   // Lowers start and waits until every row is back and the block is quiet.
   task automatic wait_idle();
      start <= 1'b0;
      while (rows_pending != 0 || busy)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // One register write beat; csr_valid is left high for the caller.
   task automatic write_register(input logic [CsrIdxW-1:0] index,
                                 input logic [DimW-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Writes both registers while the block is idle.
   task automatic apply_setting(input logic [DimW-1:0] dim_word,
                                input logic [DimW-1:0] layout_word);
      wait_idle();
      write_register(CSR_DIMENSION, dim_word);
      write_register(CSR_COLUMN_MAJOR, layout_word);
      csr_valid <= 1'b0;
      order = (dim_word == 0) ? 1 : (dim_word > DMV_MAX_DIM) ? DMV_MAX_DIM : int'(dim_word);
      settings_used++;
   endtask

   // Ends the run if it hangs.
   initial begin
      #1000000;
      $display("dense_matrix_vector_multiply: mismatch");
      $finish;
   end

   initial begin
      int              phase;
      logic [DimW-1:0] dim_word;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Row-major 2x2 built from the most negative and most positive elements and minus one LSB.
      apply_setting(5'd2, 5'b00000);
      send_beat(make_beat(OP_WRITE_MATRIX, 0, 16'h8000));
      send_beat(make_beat(OP_WRITE_MATRIX, 1, 16'h7FFF));
      send_beat(make_beat(OP_WRITE_MATRIX, 2, 16'h8000));
      send_beat(make_beat(OP_WRITE_MATRIX, 3, 16'hFFFF));
      send_beat(make_beat(OP_WRITE_VECTOR, 0, 16'h8000));
      send_beat(make_beat(OP_WRITE_VECTOR, 1, 16'h8000));
      run_multiply();

      // Same data read column-major; the layout applies at the multiply.
      apply_setting(5'd2, 5'b11111);
      run_multiply();

      // Spare opcode, vector writes past the end, and a matrix write beyond n*n
      // must all leave the next result unchanged.
      send_beat(make_beat(OP_UNUSED, 255, 16'h7FFF));
      send_beat(make_beat(OP_WRITE_VECTOR, 16, 16'h7FFF));
      send_beat(make_beat(OP_WRITE_VECTOR, 255, 16'h7FFF));
      send_beat(make_beat(OP_WRITE_MATRIX, 255, 16'h7FFF));
      run_multiply();

      // A dimension of zero behaves as one; then a real order of one.
      apply_setting(5'd0, 5'b00000);
      run_multiply();
      apply_setting(5'd1, 5'b00001);
      run_multiply();

      // Random phases: a setting, then load bursts with multiplies and some noise.
      for (phase = 0; beats_sent < BeatBudget; phase++) begin
         if (phase == 2)
            dim_word = 5'd16;
         else if (phase == 5)
            dim_word = 5'd31;
         else begin
            case ($urandom_range(0, 19))
               0:       dim_word = 5'd16;
               1:       dim_word = DimW'($urandom_range(17, 31));
               2:       dim_word = 5'd0;
               3, 4:    dim_word = DimW'($urandom_range(7, 15));
               default: dim_word = DimW'($urandom_range(1, 6));
            endcase
         end
         apply_setting(dim_word, DimW'($urandom_range(0, 31)));

         repeat ($urandom_range(1, 3)) begin
            if (beats_sent >= BeatBudget)
               break;
            // Sender gaps: light, then heavy, then none.
            idle_pct = (beats_sent < BeatBudget / 3)     ? 33 :
                       (beats_sent < 2 * BeatBudget / 3) ? 72 : 0;
            if ($urandom_range(0, 4) != 0) begin
               // Well-formed: loads inside the active matrix and vector, then a multiply.
               repeat ($urandom_range(1, 2 * order)) begin
                  if ($urandom_range(0, 2) == 0)
                     send_beat(make_beat(OP_WRITE_VECTOR, $urandom_range(0, order - 1),
                                         pick_element()));
                  else
                     send_beat(make_beat(OP_WRITE_MATRIX, $urandom_range(0, order * order - 1),
                                         pick_element()));
               end
               run_multiply();
            end else begin
               // Noise: writes anywhere, ignored beats, multiplies without fresh loads.
               repeat ($urandom_range(1, 6)) begin
                  case ($urandom_range(0, 3))
                     0: begin
                        send_beat(make_beat(OP_WRITE_MATRIX, $urandom_range(0, 255),
                                            pick_element()));
                     end
                     1: begin
                        dim_word = DimW'($urandom_range(0, 1));
                        if (dim_word == 0) begin
                           send_beat(make_beat(OP_WRITE_VECTOR, $urandom_range(16, 255),
                                               pick_element()));
                        end else begin
                           send_beat(make_beat(OP_WRITE_VECTOR, $urandom_range(0, 15),
                                               pick_element()));
                        end
                     end
                     2: send_beat(make_beat(OP_UNUSED, $urandom_range(0, 255), pick_element()));
                     default: begin
                        run_multiply();
                     end
                  endcase
               end
            end
         end
      end

      // Let the last rows come back and the pipeline settle.
      wait_idle();
      repeat (DrainCycles) @(negedge clock);

      $display("Sent %0d request beats including %0d multiplies over %0d register settings.",
               beats_sent, starts_sent, settings_used);
      $display("Compared %0d row beats with the predicted sums, %0d field errors.",
               rows_checked, mismatch_count);
      if (mismatch_count == 0 && rows_pending == 0)
         $display("dense_matrix_vector_multiply: match");
      else
         $display("dense_matrix_vector_multiply: mismatch");
      $finish;
   end

endmodule
